FILE: rtl/kml_pkg.sv
// Package for the diode-ladder state-space step: codes, widths, request types
// and the saturating add. It has no dependencies. All other files import it.
package kml_pkg;

	localparam int DATA_W          = 64;
	localparam int STAGES_DEF      = 2;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int NUM_MATS        = 5;

	localparam int OP_W    = 2;
	localparam int MSEL_W  = 3;
	localparam int ENTRY_W = 10;
	localparam int TLEN_W  = 11;
	localparam int CIDX_W  = 1;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
	localparam logic [OP_W-1:0] OP_TABLE  = 2'd2;

	localparam logic [MSEL_W-1:0] MAT_H = 3'd0;
	localparam logic [MSEL_W-1:0] MAT_J = 3'd1;
	localparam logic [MSEL_W-1:0] MAT_G = 3'd2;
	localparam logic [MSEL_W-1:0] MAT_D = 3'd3;
	localparam logic [MSEL_W-1:0] MAT_E = 3'd4;

	localparam logic [CIDX_W-1:0] CFG_PER_STAGE = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_TABLE_LEN = 1'd1;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} kml_mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] p;
	} kml_mul_rsp_t;

	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] y;
	} kml_lut_rsp_t;

	// Two's complement add that clips to the Q31.32 range on overflow.
	function automatic logic signed [DATA_W-1:0] sat_add(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W-1:0] s;
		s = a + b;
		if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
			return a[DATA_W-1] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

endpackage

FILE: rtl/k_method_diode_ladder_step.sv
// Top level of the diode-ladder state-space step: sequencer, coefficient memory, state.
// Depends on kml_pkg, kml_mul and kml_lut.
//
//  Channel  Signals                                    Direction  Moves
//  in       in_valid, in_stall, op .. entry            to block   one request
//  out      out_valid, out_stall, out_sample           from block one result
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  to block   one register write
//
// A coefficient or table request is handled as it is taken and leaves the
// sequencer idle. A sample request sends every product through a
// coefficient read and the shared multiplier, closes each row in a row step
// and runs each table lookup through the search sequencer. The shared
// multiplier and the single coefficient read port serialise the products.
// Reset clears the state vectors, the previous sample, the sequencer, the
// output valid flag and the configuration registers, but no datapath register.
// A finished result waits in the output register while the next request
// is taken; a sample completes only once that register is free.
module k_method_diode_ladder_step #(
	parameter int STAGES      = kml_pkg::STAGES_DEF,
	parameter int TABLE_DEPTH = kml_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kml_pkg::OP_W-1:0]            op,
	input  logic signed [kml_pkg::DATA_W-1:0]   value,
	input  logic signed [kml_pkg::DATA_W-1:0]   table_key,
	input  logic [kml_pkg::MSEL_W-1:0]          matrix_sel,
	input  logic                                row,
	input  logic                                col,
	input  logic                                table_sel,
	input  logic [kml_pkg::ENTRY_W-1:0]         entry,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [kml_pkg::DATA_W-1:0]   out_sample,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kml_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [kml_pkg::TLEN_W-1:0]          cfg_data
);
	import kml_pkg::*;

	localparam int RW  = $clog2(STAGES);
	localparam int TW  = $clog2(2 * STAGES + 2);
	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CD  = NUM_MATS * STAGES * STAGES;
	localparam int CAW = $clog2(CD);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_COEF = 8'b00000010,
		S_MULS = 8'b00000100,
		S_MULW = 8'b00001000,
		S_ROW  = 8'b00010000,
		S_LK   = 8'b00100000,
		S_LKW  = 8'b01000000,
		S_FIN  = 8'b10000000
	} seq_state_t;

	typedef enum logic [2:0] {
		PH_PK = 3'b001,
		PH_P  = 3'b010,
		PH_W  = 3'b100
	} phase_t;

	seq_state_t               state_q;
	phase_t                   phase_q;
	logic [RW-1:0]            i_q;
	logic [TW-1:0]            t_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] w_q  [STAGES];
	logic signed [DATA_W-1:0] y_q  [STAGES];
	logic signed [DATA_W-1:0] pk_q [STAGES];
	logic signed [DATA_W-1:0] p_q  [STAGES];
	logic signed [DATA_W-1:0] prev_q, x_q, xs_q;
	logic                     per_stage_q;
	logic [TLEN_W-1:0]        table_len_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_q;

	// Coefficient memory, five square matrices packed row by row.
	logic signed [DATA_W-1:0] coef_mem [CD];
	logic signed [DATA_W-1:0] coef_rd_q;
	logic [CAW-1:0]           coef_ra, coef_wa;
	logic                     coef_we;

	logic                     accept;
	logic                     fin_go;
	logic [MSEL_W-1:0]        t_mat;
	logic [RW-1:0]            t_col;
	logic signed [DATA_W-1:0] t_opnd;
	logic [TW-1:0]            t_last, rows, m_cnt, t_g;
	logic                     row_last;
	logic [31:0]              len_eff;
	logic [IW-1:0]            tbl_last;
	logic                     tbl_we;

	kml_mul_req_t mul_req;
	kml_mul_rsp_t mul_rsp;
	kml_lut_rsp_t lut_rsp;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

	// The finished sample moves into the output register once it is free.
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign m_cnt = per_stage_q ? TW'(STAGES) : TW'(1);
	assign t_g   = t_q - TW'(STAGES + 1);

	// Which coefficient and which operand the current product uses.
	always_comb begin
		t_mat  = MAT_H;
		t_col  = t_q[RW-1:0];
		t_opnd = w_q[t_q[RW-1:0]];
		t_last = TW'(STAGES) + m_cnt;
		rows   = TW'(STAGES);
		case (phase_q)
			PH_PK: begin
				if (t_q < TW'(STAGES)) begin
					t_mat  = MAT_H;
					t_opnd = w_q[t_q[RW-1:0]];
				end else if (t_q == TW'(STAGES)) begin
					t_mat  = MAT_J;
					t_col  = '0;
					t_opnd = xs_q;
				end else begin
					t_mat  = MAT_G;
					t_col  = t_g[RW-1:0];
					t_opnd = y_q[t_g[RW-1:0]];
				end
			end
			PH_P: begin
				t_last = TW'(STAGES);
				rows   = m_cnt;
				if (t_q < TW'(STAGES)) begin
					t_mat  = MAT_D;
					t_opnd = pk_q[t_q[RW-1:0]];
				end else begin
					t_mat  = MAT_E;
					t_col  = '0;
					t_opnd = x_q;
				end
			end
			PH_W: begin
				t_last = m_cnt - TW'(1);
				t_mat  = MAT_G;
				t_opnd = y_q[t_q[RW-1:0]];
			end
			default: ;
		endcase
	end

	assign row_last = (TW'(i_q) == rows - TW'(1));

	assign coef_ra = CAW'(t_mat) * CAW'(STAGES * STAGES) + CAW'(i_q) * CAW'(STAGES)
		+ CAW'(t_col);
	assign coef_wa = CAW'(matrix_sel) * CAW'(STAGES * STAGES) + CAW'(row) * CAW'(STAGES)
		+ CAW'(col);
	assign coef_we = accept && (op == OP_COEF) && (matrix_sel < MSEL_W'(NUM_MATS))
		&& (32'(row) < STAGES) && (32'(col) < STAGES);

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= value;
		end
		coef_rd_q <= coef_mem[coef_ra];
	end

	// Table length clipped to the range the memory can hold.
	always_comb begin
		len_eff = 32'(table_len_q);
		if (len_eff == 32'd0) begin
			len_eff = 32'd1;
		end else if (len_eff > TABLE_DEPTH) begin
			len_eff = TABLE_DEPTH;
		end
	end
	assign tbl_last = IW'(len_eff - 32'd1);

	assign tbl_we = accept && (op == OP_TABLE) && (32'(table_sel) < STAGES)
		&& (32'(entry) < TABLE_DEPTH);

	assign mul_req.start = (state_q == S_MULS);
	assign mul_req.a     = coef_rd_q;
	assign mul_req.b     = t_opnd;

	kml_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	kml_lut #(
		.STAGES      (STAGES),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_lut (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (tbl_we),
		.wr_tbl (RW'(table_sel)),
		.wr_idx (IW'(entry)),
		.wr_key (table_key),
		.wr_cur (value),
		.start  (state_q == S_LK),
		.rd_tbl (i_q),
		.p      (p_q[i_q]),
		.last   (tbl_last),
		.rsp    (lut_rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_stage_q <= 1'b0;
			table_len_q <= TLEN_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PER_STAGE: per_stage_q <= cfg_data[0];
				CFG_TABLE_LEN: table_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output register: filled by a finished sample, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and filter state. The state vector, the nonlinear vector and
	// the previous sample are part of the filter's reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_PK;
			i_q         <= '0;
			t_q         <= '0;
			prev_q      <= '0;
			for (int s = 0; s < STAGES; s++) begin
				w_q[s] <= '0;
				y_q[s] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_SAMPLE)) begin
						phase_q <= PH_PK;
						i_q     <= '0;
						t_q     <= '0;
						state_q <= S_COEF;
					end
				end
				S_COEF: state_q <= S_MULS;
				S_MULS: state_q <= S_MULW;
				S_MULW: begin
					if (mul_rsp.done) begin
						if (t_q == t_last) begin
							state_q <= S_ROW;
						end else begin
							t_q     <= t_q + TW'(1);
							state_q <= S_COEF;
						end
					end
				end
				S_ROW: begin
					t_q <= '0;
					case (phase_q)
						PH_PK: w_q[i_q] <= w_q[i_q];
						PH_W:  w_q[i_q] <= sat_add(acc_q, pk_q[i_q]);
						default: ;
					endcase
					if (row_last) begin
						i_q <= '0;
						case (phase_q)
							PH_PK: begin
								phase_q <= PH_P;
								state_q <= S_COEF;
							end
							PH_P:  state_q <= S_LK;
							default: state_q <= S_FIN;
						endcase
					end else begin
						i_q     <= i_q + RW'(1);
						state_q <= S_COEF;
					end
				end
				S_LK: state_q <= S_LKW;
				S_LKW: begin
					if (lut_rsp.done) begin
						y_q[i_q] <= lut_rsp.y;
						if (TW'(i_q) == m_cnt - TW'(1)) begin
							i_q     <= '0;
							phase_q <= PH_W;
							state_q <= S_COEF;
						end else begin
							i_q     <= i_q + RW'(1);
							state_q <= S_LK;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						prev_q  <= x_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (op == OP_SAMPLE)) begin
					x_q   <= value;
					xs_q  <= sat_add(value, prev_q);
					acc_q <= '0;
				end
			end
			S_MULW: begin
				if (mul_rsp.done) begin
					acc_q <= sat_add(acc_q, mul_rsp.p);
				end
			end
			S_ROW: begin
				acc_q <= '0;
				case (phase_q)
					PH_PK: pk_q[i_q] <= acc_q;
					PH_P:  p_q[i_q]  <= acc_q;
					default: ;
				endcase
			end
			S_FIN: begin
				if (fin_go) begin
					out_q <= w_q[0];
				end
			end
			default: ;
		endcase
	end

	// A result appears only on completion of a sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside sample completion");

	// An accepted sample keeps the input side stalled in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (op == OP_SAMPLE)) |=> in_stall)
		else $error("sample request did not start the sequencer");

	// Lookups are only started for tables that are in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LK) |-> (TW'(i_q) < m_cnt))
		else $error("lookup started for an unused table");

	// The multiplier answers only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_MULW))
		else $error("multiplier result arrived unexpectedly");

endmodule

FILE: rtl/kml_mul.sv
// Iterative Q31.32 multiplier: four 32x32 partial products, rounding, saturation.
// Depends on kml_pkg.
module kml_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kml_pkg::kml_mul_req_t req,
	output kml_pkg::kml_mul_rsp_t rsp
);
	import kml_pkg::*;

	logic                     busy_q;
	logic [2:0]               cnt_q;
	logic                     done_q;
	logic [DATA_W-1:0]        ma_q, mb_q;
	logic                     neg_q;
	logic [DATA_W-1:0]        pp_q;
	logic [1:0]               sel_q;
	logic [2*DATA_W-1:0]      acc_q;
	logic signed [DATA_W-1:0] res_q;
	logic [31:0]              a_part, b_part;
	logic [2*DATA_W-1:0]      pp_shift;
	logic [DATA_W-1:0]        r_mag;
	logic signed [DATA_W-1:0] res_d;

	assign a_part = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign b_part = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		case (sel_q)
			2'd0:    pp_shift = {64'd0, pp_q};
			2'd3:    pp_shift = {pp_q, 64'd0};
			default: pp_shift = {32'd0, pp_q, 32'd0};
		endcase
	end

	// The accumulator starts at one half LSB of the result, so the final
	// slice is already rounded half away from zero on the magnitude.
	assign r_mag = acc_q[95:32];
	always_comb begin
		if (acc_q[127:96] != 32'd0) begin
			res_d = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			res_d = (r_mag > 64'h8000_0000_0000_0000) ? Q_MIN : -$signed(r_mag);
		end else begin
			res_d = r_mag[63] ? Q_MAX : $signed(r_mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			mb_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= 128'h8000_0000;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q  <= a_part * b_part;
				sel_q <= cnt_q[1:0];
			end
			if ((cnt_q >= 3'd1) && (cnt_q <= 3'd4)) begin
				acc_q <= acc_q + pp_shift;
			end
			if (cnt_q == 3'd5) begin
				res_q <= res_d;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = res_q;

endmodule

FILE: rtl/kml_lut.sv
// Nearest-key table lookup: key and current memories and a binary search sequencer.
// Depends on kml_pkg.
module kml_lut #(
	parameter int STAGES      = kml_pkg::STAGES_DEF,
	parameter int TABLE_DEPTH = kml_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [$clog2(STAGES)-1:0]              wr_tbl,
	input  logic [$clog2(TABLE_DEPTH)-1:0]         wr_idx,
	input  logic signed [kml_pkg::DATA_W-1:0]      wr_key,
	input  logic signed [kml_pkg::DATA_W-1:0]      wr_cur,
	input  logic                                   start,
	input  logic [$clog2(STAGES)-1:0]              rd_tbl,
	input  logic signed [kml_pkg::DATA_W-1:0]      p,
	input  logic [$clog2(TABLE_DEPTH)-1:0]         last,
	output kml_pkg::kml_lut_rsp_t                  rsp
);
	import kml_pkg::*;

	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int TSW   = $clog2(STAGES);
	localparam int DEPTH = STAGES * TABLE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [10:0] {
		L_IDLE = 11'b00000000001,
		L_RD0  = 11'b00000000010,
		L_CK0  = 11'b00000000100,
		L_RDL  = 11'b00000001000,
		L_CKL  = 11'b00000010000,
		L_RDM  = 11'b00000100000,
		L_CKM  = 11'b00001000000,
		L_RDA  = 11'b00010000000,
		L_CKA  = 11'b00100000000,
		L_RDB  = 11'b01000000000,
		L_CKB  = 11'b10000000000
	} lut_state_t;

	logic signed [DATA_W-1:0] keys_mem [DEPTH];
	logic signed [DATA_W-1:0] curs_mem [DEPTH];
	logic signed [DATA_W-1:0] key_rd_q, cur_rd_q;

	lut_state_t               st_q;
	logic                     done_q;
	logic [TSW-1:0]           tbl_q;
	logic signed [DATA_W-1:0] p_q;
	logic [IW-1:0]            last_q, lo_q, hi_q;
	logic signed [DATA_W-1:0] ka_q, ca_q, y_q;
	logic [IW-1:0]            mid, rd_idx, nlo, nhi;
	logic [AW-1:0]            rd_addr, wr_addr;
	logic [DATA_W-1:0]        dl, dh;

	assign mid = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		case (st_q)
			L_RDL:   rd_idx = last_q;
			L_RDM:   rd_idx = mid;
			L_RDA:   rd_idx = lo_q - IW'(1);
			L_RDB:   rd_idx = lo_q;
			default: rd_idx = '0;
		endcase
	end

	assign rd_addr = AW'(tbl_q) * AW'(TABLE_DEPTH) + AW'(rd_idx);
	assign wr_addr = AW'(wr_tbl) * AW'(TABLE_DEPTH) + AW'(wr_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			keys_mem[wr_addr] <= wr_key;
			curs_mem[wr_addr] <= wr_cur;
		end
		key_rd_q <= keys_mem[rd_addr];
		cur_rd_q <= curs_mem[rd_addr];
	end

	// Halving step of the search for the first key not below p.
	always_comb begin
		if (key_rd_q >= p_q) begin
			nlo = lo_q;
			nhi = mid;
		end else begin
			nlo = mid + IW'(1);
			nhi = hi_q;
		end
	end

	assign dl = 64'(p_q) - 64'(ka_q);
	assign dh = 64'(key_rd_q) - 64'(p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: if (start) st_q <= L_RD0;
				L_RD0:  st_q <= L_CK0;
				L_CK0: begin
					if (p_q <= key_rd_q) begin
						done_q <= 1'b1;
						st_q   <= L_IDLE;
					end else begin
						st_q <= L_RDL;
					end
				end
				L_RDL:  st_q <= L_CKL;
				L_CKL: begin
					if (p_q >= key_rd_q) begin
						done_q <= 1'b1;
						st_q   <= L_IDLE;
					end else begin
						st_q <= (last_q > IW'(1)) ? L_RDM : L_RDA;
					end
				end
				L_RDM:  st_q <= L_CKM;
				L_CKM:  st_q <= (nlo < nhi) ? L_RDM : L_RDA;
				L_RDA:  st_q <= L_CKA;
				L_CKA:  st_q <= L_RDB;
				L_RDB:  st_q <= L_CKB;
				L_CKB: begin
					done_q <= 1'b1;
					st_q   <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					tbl_q  <= rd_tbl;
					p_q    <= p;
					last_q <= last;
				end
			end
			L_CK0: y_q <= cur_rd_q;
			L_CKL: begin
				y_q  <= cur_rd_q;
				lo_q <= IW'(1);
				hi_q <= last_q;
			end
			L_CKM: begin
				lo_q <= nlo;
				hi_q <= nhi;
			end
			L_CKA: begin
				ka_q <= key_rd_q;
				ca_q <= cur_rd_q;
			end
			L_CKB: y_q <= (dl < dh) ? ca_q : cur_rd_q;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.y    = y_q;

endmodule
